/* rtl/ip_address_text_parser_defines.svh */
// Assertion macros for the IP address text parser.
// Used by the RTL modules; expects signals clk and rst_n in scope.
`ifndef IP_ADDRESS_TEXT_PARSER_DEFINES_SVH
`define IP_ADDRESS_TEXT_PARSER_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define IPATP_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ipatp: same-cycle check failed");

// antecedent implies consequent in the following cycle
`define IPATP_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ipatp: next-cycle check failed");

`endif

/* rtl/ipatp_pkg.sv */
// Types and helper functions for the IP address text parser.
// No dependencies; imported by ipatp_core and ip_address_text_parser.
package ipatp_pkg;

    typedef enum logic [2:0] {
        PH_START = 3'd0,
        PH_V4    = 3'd1,
        PH_V6    = 3'd2,
        PH_LEAD  = 3'd3,
        PH_TRAIL = 3'd4,
        PH_DEAD  = 3'd5
    } phase_t;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef struct packed {
        phase_t         phase;
        logic           fam;
        logic [127:0]   addr;
        logic [4:0]     wp;
        logic [4:0]     gp;
        logic           gap_seen;
        logic           saw_hex;
        logic [15:0]    hex;
        logic           pending;
        logic [8:0]     dec;
        logic [3:0]     tok;    // [1:0] digit count, [2] lead zero, [3] bad
        logic [7:0]     q0;
        logic [7:0]     q1;
        logic [7:0]     q2;
        logic [1:0]     pc;
    } st_t;

    typedef struct packed {
        logic           fire;
        logic           ok;
        logic [63:0]    hi;
        logic [63:0]    lo;
    } res_t;

    typedef struct packed {
        logic           ok;
        logic [127:0]   addr;
    } fin_t;

    function automatic st_t tok_digit(st_t s, logic [3:0] d);
        logic [11:0] t;
        t = ({3'b0, s.dec} * 12'd10) + {8'b0, d};
        if (s.tok[1:0] == 2'd0)
        begin
            if (d == 4'd0)
                s.tok[2] = 1'b1;
        end
        else if (s.tok[1:0] == 2'd1 && s.tok[2] && d != 4'd9)
        begin
            s.tok[3] = 1'b1;
        end
        if (s.tok[1:0] != 2'd2)
            s.tok[1:0] = s.tok[1:0] + 2'd1;
        s.dec = (t > 12'd256) ? 9'd256 : t[8:0];
        return s;
    endfunction

    function automatic logic tok_ok(st_t s);
        return (s.tok[1:0] != 2'd0) && !s.tok[3] && (s.dec <= 9'd255);
    endfunction

    // dotted tail placement, last group flush and gap shift
    function automatic fin_t ipatp_finish(st_t s, logic v4_path);
        fin_t         r;
        logic [127:0] v;
        logic [127:0] keep;
        logic [4:0]   w;
        logic         ok;
        logic [31:0]  quad;
        v    = s.addr;
        w    = s.wp;
        ok   = 1'b1;
        quad = {s.q0, s.q1, s.q2, s.dec[7:0]};
        if (v4_path)
        begin
            ok = tok_ok(s) && (s.pc == 2'd3) && (s.wp <= 5'd12);
            v  = v | ({quad, 96'b0} >> {w, 3'b0});
            w  = w + 5'd4;
        end
        if (!v4_path || s.fam)
        begin
            if (s.saw_hex)
            begin
                if (w > 5'd14)
                    ok = 1'b0;
                v = v | ({s.hex, 112'b0} >> {w, 3'b0});
                w = w + 5'd2;
            end
            if (s.gap_seen)
            begin
                if (w >= 5'd16 || s.gp > w)
                    ok = 1'b0;
                keep = ~({128{1'b1}} >> {s.gp, 3'b0});
                v    = (v & keep) | ((v & ~keep) >> {5'd16 - w, 3'b0});
                w    = 5'd16;
            end
            if (w != 5'd16)
                ok = 1'b0;
        end
        r.ok   = ok;
        r.addr = v;
        return r;
    endfunction

endpackage

/* rtl/ipatp_core.sv */
// Parse state registers and per-character update for the address parser.
// Depends on ipatp_pkg; instantiated by ip_address_text_parser.
module ipatp_core
    import ipatp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] char_code,
    input  logic       want_ipv6,
    output res_t       res
);

    st_t st_reg;
    st_t st_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= '0;
        else
            st_reg <= st_next;
    end

    always_comb
    begin
        st_t        n;
        fin_t       f;
        logic       go;
        logic       is_hex;
        logic [3:0] h;
        logic [7:0] c;
        logic       ok;
        logic [127:0] a;
        n      = st_reg;
        c      = char_code;
        go     = 1'b1;
        ok     = 1'b0;
        a      = '0;
        res    = '0;
        is_hex = 1'b1;
        h      = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
            h = 4'(c - 8'h30);
        else if (c >= 8'h61 && c <= 8'h66)
            h = 4'(c - 8'h57);
        else if (c >= 8'h41 && c <= 8'h46)
            h = 4'(c - 8'h37);
        else
            is_hex = 1'b0;

        if (step)
        begin
            if (n.phase == PH_START)
            begin
                n     = '0;
                n.fam = want_ipv6;
                if (want_ipv6 && c == CH_COLON)
                begin
                    n.phase = PH_LEAD;
                    go      = 1'b0;
                end
                else
                begin
                    n.phase = want_ipv6 ? PH_V6 : PH_V4;
                end
            end
            if (go && c != CH_NUL)
            begin
                if (n.phase == PH_LEAD)
                    n.phase = (c == CH_COLON) ? PH_V6 : PH_DEAD;
                unique case (n.phase)
                    PH_V4:
                    begin
                        if (c >= 8'h30 && c <= 8'h39)
                        begin
                            n = tok_digit(n, h);
                            if (n.tok[3])
                                n.phase = PH_DEAD;
                        end
                        else if (c == CH_DOT)
                        begin
                            if (n.tok[1:0] == 2'd0 || n.dec > 9'd255 || n.pc == 2'd3)
                                n.phase = PH_DEAD;
                            else
                            begin
                                if (n.pc == 2'd0)
                                    n.q0 = n.dec[7:0];
                                else if (n.pc == 2'd1)
                                    n.q1 = n.dec[7:0];
                                else
                                    n.q2 = n.dec[7:0];
                                n.pc  = n.pc + 2'd1;
                                n.dec = '0;
                                n.tok = '0;
                            end
                        end
                        else if (c == CH_SPACE || (c >= 8'd9 && c <= 8'd13))
                        begin
                            f       = ipatp_finish(n, 1'b1);
                            n.addr  = f.addr;
                            n.phase = f.ok ? PH_TRAIL : PH_DEAD;
                        end
                        else
                        begin
                            n.phase = PH_DEAD;
                        end
                    end
                    PH_V6:
                    begin
                        n.pending = 1'b0;
                        if (is_hex)
                        begin
                            if (n.hex[15:12] != 4'd0)
                                n.phase = PH_DEAD;
                            else
                            begin
                                n.hex     = {n.hex[11:0], h};
                                n.saw_hex = 1'b1;
                                if (h < 4'd10)
                                    n = tok_digit(n, h);
                                else
                                    n.tok[3] = 1'b1;
                            end
                        end
                        else if (c == CH_COLON)
                        begin
                            n.dec = '0;
                            n.tok = '0;
                            if (!n.saw_hex)
                            begin
                                if (n.gap_seen)
                                    n.phase = PH_DEAD;
                                else
                                begin
                                    n.gap_seen = 1'b1;
                                    n.gp       = n.wp;
                                end
                            end
                            else if (n.wp > 5'd14)
                                n.phase = PH_DEAD;
                            else
                            begin
                                n.addr    = n.addr | ({n.hex, 112'b0} >> {n.wp, 3'b0});
                                n.wp      = n.wp + 5'd2;
                                n.saw_hex = 1'b0;
                                n.hex     = '0;
                                n.pending = 1'b1;
                            end
                        end
                        else if (c == CH_DOT && n.wp <= 5'd12 && tok_ok(n))
                        begin
                            n.q0      = n.dec[7:0];
                            n.pc      = 2'd1;
                            n.dec     = '0;
                            n.tok     = '0;
                            n.saw_hex = 1'b0;
                            n.phase   = PH_V4;
                        end
                        else
                        begin
                            n.phase = PH_DEAD;
                        end
                    end
                    PH_TRAIL: ;
                    default: n.phase = PH_DEAD;
                endcase
            end
            else if (go)
            begin
                f = ipatp_finish(n, n.phase == PH_V4);
                unique case (n.phase)
                    PH_V4:    ok = f.ok;
                    PH_V6:    ok = !n.pending && f.ok;
                    PH_TRAIL: ok = 1'b1;
                    default:  ok = 1'b0;
                endcase
                a        = (n.phase == PH_TRAIL) ? n.addr : f.addr;
                res.fire = 1'b1;
                res.ok   = ok;
                if (ok && n.fam)
                begin
                    res.hi = a[127:64];
                    res.lo = a[63:0];
                end
                else if (ok)
                begin
                    res.lo = {32'b0, a[127:96]};
                end
                n = '0;
            end
        end
        st_next = n;
    end

endmodule

/* rtl/ip_address_text_parser.sv */
// Top level of the IP address text parser: input word register, parse core,
// result register. Depends on ipatp_pkg, ipatp_core and the defines header.
//
//  channel | dir | tdata             | tuser
//  s_*     | in  | char_code [7:0]   | want_ipv6 [0]
//  m_*     | out | addr_high, addr_low | is_valid [0]
//
// One character word per cycle unless a NUL word waits; its result is registered as it advances.
// The parse state loop in ipatp_core sets the rate: one update per cycle while characters advance.
// A NUL word waits in the input register only while a result is unread.
// rst_n clears the parse state and both valid flags asynchronously.
`include "ip_address_text_parser_defines.svh"

module ip_address_text_parser
    import ipatp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // char_code
    input  logic [0:0]   s_tuser,   // want_ipv6
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // addr_high [63:0], addr_low [127:64]
    output logic [0:0]   m_tuser    // is_valid
);

    logic         in_valid_reg;
    logic [7:0]   char_reg;
    logic         want_reg;
    logic         out_valid_reg;
    logic [127:0] data_reg;
    logic         ok_reg;
    logic         is_nul;
    logic         adv;
    res_t         res;

    assign is_nul   = (char_reg == CH_NUL);
    assign adv      = in_valid_reg && (!is_nul || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || adv;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = ok_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                in_valid_reg <= 1'b1;
            else if (adv)
                in_valid_reg <= 1'b0;
            if (adv && res.fire)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            char_reg <= s_tdata;
            want_reg <= s_tuser[0];
        end
        if (adv && res.fire)
        begin
            data_reg <= {res.lo, res.hi};
            ok_reg   <= res.ok;
        end
    end

    ipatp_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (adv),
        .char_code (char_reg),
        .want_ipv6 (want_reg),
        .res       (res)
    );

    `IPATP_ASSERT_NOW(a_invalid_zero, m_tvalid && !m_tuser[0], m_tdata == 128'b0)
    `IPATP_ASSERT_NEXT(a_nul_result, adv && is_nul, out_valid_reg)
    `IPATP_ASSERT_NEXT(a_hold_input, in_valid_reg && !adv, in_valid_reg)

endmodule
